// ----- rtl/qdv_pkg.sv -----
// Shared types, constants and the quadrature transition table for the detent volume block.
`timescale 1ns / 1ps
`default_nettype none

package qdv_pkg;

   localparam int VOL_W   = 7;
   localparam int ACC_W   = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [VOL_W-1:0] VOLUME_RESET      = 7'd10;
   localparam logic [VOL_W-1:0] NIGHT_LIMIT_RESET = 7'd10;
   localparam logic [VOL_W-1:0] DAY_LIMIT_RESET   = 7'd100;
   localparam logic [VOL_W-1:0] STEP_RESET        = 7'd3;

   localparam logic signed [ACC_W:0] QUARTERS_PER_DETENT = 4'sd4;

   localparam logic signed [1:0] DETENT_UP   = 2'sb01;
   localparam logic signed [1:0] DETENT_DOWN = 2'sb11;
   localparam logic signed [1:0] DETENT_NONE = 2'sb00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NIGHT_MODE       = 3'd0,
      CSR_INVERT_DIRECTION = 3'd1,
      CSR_NIGHT_LIMIT      = 3'd2,
      CSR_DAY_LIMIT        = 3'd3,
      CSR_VOLUME_STEP      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             night_mode;
      logic             invert_direction;
      logic [VOL_W-1:0] night_limit;
      logic [VOL_W-1:0] day_limit;
      logic [VOL_W-1:0] volume_step;
   } cfg_type;

   // Quarter steps for each {previous phase, current phase} pair.
   localparam logic signed [1:0] STEP_TABLE [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

endpackage

`default_nettype wire

// ----- rtl/qdv_csr.sv -----
// Configuration register file for the detent volume block.
`timescale 1ns / 1ps
`default_nettype none

module qdv_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [qdv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qdv_pkg::VOL_W-1:0]       csr_wdata,
   output qdv_pkg::cfg_type                     cfg
);
   import qdv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_NIGHT_MODE:       cfg_in.night_mode       = csr_wdata[0];
            CSR_INVERT_DIRECTION: cfg_in.invert_direction = csr_wdata[0];
            CSR_NIGHT_LIMIT:      cfg_in.night_limit      = csr_wdata;
            CSR_DAY_LIMIT:        cfg_in.day_limit        = csr_wdata;
            CSR_VOLUME_STEP:      cfg_in.volume_step      = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_mode       <= 1'b0;
         cfg_ff.invert_direction <= 1'b0;
         cfg_ff.night_limit      <= NIGHT_LIMIT_RESET;
         cfg_ff.day_limit        <= DAY_LIMIT_RESET;
         cfg_ff.volume_step      <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/qdv_step.sv -----
// Decoder and volume state, updated from one phase sample whenever advance is high.
`timescale 1ns / 1ps
`default_nettype none

module qdv_step (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        phase_a,
   input  wire logic                        phase_b,
   input  wire qdv_pkg::cfg_type            cfg,
   output logic [qdv_pkg::VOL_W-1:0]        volume,
   output logic                             volume_changed,
   output logic signed [1:0]                detent
);
   import qdv_pkg::*;

   logic                    primed_ff, primed_in;
   logic [1:0]              prev_phase_ff, prev_phase_in;
   logic signed [ACC_W-1:0] accum_ff, accum_in;
   logic [VOL_W-1:0]        level_ff, level_in;

   logic [1:0]              cur;
   logic [VOL_W-1:0]        limit;
   logic [VOL_W-1:0]        vclamp;
   logic signed [1:0]       quarter;
   logic signed [ACC_W:0]   sum;
   logic signed [1:0]       raw_detent;
   logic [VOL_W:0]          up_sum;
   logic [VOL_W-1:0]        up_val;
   logic [VOL_W-1:0]        dn_val;

   always_comb begin
      cur     = {phase_a, phase_b};
      limit   = cfg.night_mode ? cfg.night_limit : cfg.day_limit;
      vclamp  = (level_ff > limit) ? limit : level_ff;
      quarter = STEP_TABLE[{prev_phase_ff, cur}];
      sum     = (ACC_W+1)'(accum_ff) + (ACC_W+1)'(quarter);

      prev_phase_in = cur;
      primed_in     = 1'b1;
      raw_detent    = DETENT_NONE;
      if (!primed_ff) begin
         accum_in = '0;
      end else if (sum >= QUARTERS_PER_DETENT) begin
         raw_detent = DETENT_UP;
         accum_in   = ACC_W'(sum - QUARTERS_PER_DETENT);
      end else if (sum <= -QUARTERS_PER_DETENT) begin
         raw_detent = DETENT_DOWN;
         accum_in   = ACC_W'(sum + QUARTERS_PER_DETENT);
      end else begin
         accum_in = ACC_W'(sum);
      end

      detent = cfg.invert_direction ? -raw_detent : raw_detent;

      // saturate to the active limit going up and to zero going down
      up_sum = {1'b0, vclamp} + {1'b0, cfg.volume_step};
      up_val = (up_sum > {1'b0, limit}) ? limit : up_sum[VOL_W-1:0];
      dn_val = (cfg.volume_step > vclamp) ? '0 : vclamp - cfg.volume_step;

      priority if (detent == DETENT_UP) begin
         level_in = up_val;
      end else if (detent == DETENT_DOWN) begin
         level_in = dn_val;
      end else begin
         level_in = vclamp;
      end

      volume         = level_in;
      volume_changed = (level_in != level_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff     <= 1'b0;
         prev_phase_ff <= '0;
         accum_ff      <= '0;
         level_ff      <= VOLUME_RESET;
      end else if (advance) begin
         primed_ff     <= primed_in;
         prev_phase_ff <= prev_phase_in;
         accum_ff      <= accum_in;
         level_ff      <= level_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/quadrature_detent_volume.sv -----
// Top level of the quadrature detent volume block: input register, update, result register.
`timescale 1ns / 1ps
`default_nettype none

// Rotary encoder to volume control. Each transaction on req_ carries one sampled
// encoder phase (A high bit, B low bit) and yields exactly one rsp_ transaction with
// the volume, a changed flag and the signed detent (+1, -1 or 0). The first sample
// after reset only primes the decoder. One sample is taken every clock while req_stall
// is low; each sample passes through the input register, then the result register,
// and the decoder and volume state update as the sample moves from the input register
// to the result register. Write csr_ registers only while no transaction is in flight.
module quadrature_detent_volume (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_phase_a,
   input  wire logic                          req_phase_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [qdv_pkg::VOL_W-1:0]          rsp_volume,
   output logic                               rsp_volume_changed,
   output logic signed [1:0]                  rsp_detent,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [qdv_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [qdv_pkg::VOL_W-1:0]     csr_wdata
);
   import qdv_pkg::*;

   cfg_type cfg;

   logic               in_valid_ff, in_valid_in;
   logic               in_a_ff, in_b_ff;
   logic               out_valid_ff, out_valid_in;
   logic [VOL_W-1:0]   out_volume_ff;
   logic               out_changed_ff;
   logic signed [1:0]  out_detent_ff;

   logic               out_load;
   logic               advance;
   logic               in_load;
   logic [VOL_W-1:0]   step_volume;
   logic               step_changed;
   logic signed [1:0]  step_detent;

   qdv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qdv_step u_step (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .phase_a        (in_a_ff),
      .phase_b        (in_b_ff),
      .cfg            (cfg),
      .volume         (step_volume),
      .volume_changed (step_changed),
      .detent         (step_detent)
   );

   always_comb begin
      out_load     = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_load;
      req_stall    = in_valid_ff && !out_load;
      in_load      = req_valid && !req_stall;
      in_valid_in  = in_load || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the sample until it moves into the result register
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_a_ff <= req_phase_a;
         in_b_ff <= req_phase_b;
      end
      if (advance) begin
         out_volume_ff  <= step_volume;
         out_changed_ff <= step_changed;
         out_detent_ff  <= step_detent;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_volume         = out_volume_ff;
   assign rsp_volume_changed = out_changed_ff;
   assign rsp_detent         = out_detent_ff;

endmodule

`default_nettype wire
